// ----- rtl/sample_standard_deviation_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sample standard deviation unit
// Each macro checks a property on the rising edge of clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_STANDARD_DEVIATION_UNIT_ASSERT_SVH
`define SAMPLE_STANDARD_DEVIATION_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SSD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssd assertion failed");
// next-cycle implication
`define SSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssd assertion failed");
`else
`define SSD_ASSERT_IMPL(lbl, ante, cons)
`define SSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// ssd_pkg
// Widths, status codes and shared types of the standard deviation unit.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int DATA_W  = 24;  // sample field
  localparam int CNT_W   = 17;  // sample count
  localparam int SUM_W   = 40;  // running sum, two's complement
  localparam int SSQ_W   = 64;  // running sum of squares
  localparam int SD_W    = 32;  // result
  localparam int STAT_W  = 2;

  localparam int DEF_MAX_SAMPLES  = 65536;
  localparam int DEF_SAMPLE_WIDTH = 24;

  // engine datapath widths
  localparam int FRAC_SHIFT = 16;                 // variance scale 2^16
  localparam int MAG_W      = SUM_W;              // |sum|
  localparam int ALU_W      = CNT_W + SSQ_W;      // N*SS, widest operand
  localparam int DIV_W      = ALU_W + FRAC_SHIFT; // scaled dividend
  localparam int D_W        = 2 * CNT_W;          // N*(N-1)
  localparam int REM_W      = D_W + 2;            // divide / root partial remainder
  localparam int VAR_W      = 64;                 // variance before the root

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SINGLE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROP   = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] sum;
    logic [SSQ_W-1:0]        ssq;
  } ssd_opnd_t;

  typedef struct packed {
    logic            done;
    logic [SD_W-1:0] sd;
  } ssd_res_t;

endpackage

// ----- rtl/ssd_engine.sv -----
// ----------------------------------------------------------------------------
// ssd_engine
// Sequencer around one shared 81-bit add/subtract unit: shift-add products
// N*SS and S*S, difference, restoring divide by N*(N-1), digit-by-digit root.
// ----------------------------------------------------------------------------
module ssd_engine
  import ssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ssd_opnd_t opnd,
  output ssd_res_t  res
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MUL1 = 3'd1;
  localparam logic [2:0] P_MUL2 = 3'd2;
  localparam logic [2:0] P_SUB  = 3'd3;
  localparam logic [2:0] P_DIV  = 3'd4;
  localparam logic [2:0] P_SQRT = 3'd5;

  localparam int CNT_STEP_W = $clog2(DIV_W);

  logic [2:0]            phase_r, phase_nxt;
  logic [CNT_STEP_W-1:0] step_r, step_nxt;
  logic                  done_r, done_nxt;
  logic [ALU_W-1:0]      acc_r, acc_nxt;
  logic [DIV_W-1:0]      x_r, x_nxt;
  logic [MAG_W-1:0]      mr_r, mr_nxt;
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic [D_W-1:0]        d_r, d_nxt;
  logic [VAR_W-1:0]      q_r, q_nxt;
  logic                  big_r, big_nxt;

  logic [ALU_W-1:0]      alu_a, alu_b, alu_y;
  logic                  alu_sub, alu_carry, alu_borrow;
  logic [REM_W-1:0]      div_rem, sqrt_rem;
  logic                  qbit;

  // shared adder: a + b, or a - b with borrow when a < b
  assign {alu_carry, alu_y} = {1'b0, alu_a} + {1'b0, alu_b ^ {ALU_W{alu_sub}}}
                            + (ALU_W+1)'(alu_sub);
  assign alu_borrow = alu_sub & ~alu_carry;

  assign div_rem  = {acc_r[REM_W-2:0], x_r[DIV_W-1]};
  assign sqrt_rem = {acc_r[REM_W-3:0], q_r[VAR_W-1 -: 2]};
  assign qbit     = ~alu_borrow;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (phase_r)
      P_MUL1: begin
        alu_a = {acc_r[ALU_W-2:0], 1'b0};
        alu_b = mr_r[MAG_W-1] ? ALU_W'(opnd.ssq) : '0;
      end
      P_MUL2: begin
        alu_a = {acc_r[ALU_W-2:0], 1'b0};
        alu_b = mr_r[MAG_W-1] ? ALU_W'(mag_r) : '0;
      end
      P_SUB: begin
        alu_a   = x_r[ALU_W-1:0];
        alu_b   = acc_r;
        alu_sub = 1'b1;
      end
      P_DIV: begin
        alu_a   = ALU_W'(div_rem);
        alu_b   = ALU_W'(d_r);
        alu_sub = 1'b1;
      end
      P_SQRT: begin
        alu_a   = ALU_W'(sqrt_rem);
        alu_b   = ALU_W'({mr_r[SD_W-1:0], 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    mr_nxt    = mr_r;
    mag_nxt   = mag_r;
    d_nxt     = d_r;
    q_nxt     = q_r;
    big_nxt   = big_r;
    unique case (phase_r)
      P_IDLE: begin
        if (start) begin
          mag_nxt   = opnd.sum[SUM_W-1] ? MAG_W'(-opnd.sum) : MAG_W'(opnd.sum);
          d_nxt     = D_W'(opnd.n) * D_W'(opnd.n - CNT_W'(1));
          mr_nxt    = {opnd.n, {(MAG_W-CNT_W){1'b0}}};
          acc_nxt   = '0;
          step_nxt  = CNT_STEP_W'(CNT_W - 1);
          phase_nxt = P_MUL1;
        end
      end
      P_MUL1: begin
        acc_nxt  = alu_y;
        mr_nxt   = {mr_r[MAG_W-2:0], 1'b0};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          // park N*SS, start S*S
          x_nxt     = DIV_W'(alu_y);
          acc_nxt   = '0;
          mr_nxt    = mag_r;
          step_nxt  = CNT_STEP_W'(MAG_W - 1);
          phase_nxt = P_MUL2;
        end
      end
      P_MUL2: begin
        acc_nxt  = alu_y;
        mr_nxt   = {mr_r[MAG_W-2:0], 1'b0};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          phase_nxt = P_SUB;
        end
      end
      P_SUB: begin
        // clamp a negative difference to zero, then scale by 2^16
        x_nxt     = {(alu_borrow ? ALU_W'(0) : alu_y), {FRAC_SHIFT{1'b0}}};
        acc_nxt   = '0;
        big_nxt   = 1'b0;
        step_nxt  = CNT_STEP_W'(DIV_W - 1);
        phase_nxt = P_DIV;
      end
      P_DIV: begin
        acc_nxt  = qbit ? alu_y : ALU_W'(div_rem);
        x_nxt    = {x_r[DIV_W-2:0], 1'b0};
        q_nxt    = {q_r[VAR_W-2:0], qbit};
        big_nxt  = big_r | (qbit & (step_r >= CNT_STEP_W'(VAR_W)));
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          // saturate a quotient beyond 64 bits
          q_nxt     = big_nxt ? '1 : {q_r[VAR_W-2:0], qbit};
          acc_nxt   = '0;
          mr_nxt    = '0;
          step_nxt  = CNT_STEP_W'(SD_W - 1);
          phase_nxt = P_SQRT;
        end
      end
      P_SQRT: begin
        acc_nxt  = alu_borrow ? ALU_W'(sqrt_rem) : alu_y;
        mr_nxt   = {mr_r[MAG_W-2:0], ~alu_borrow};
        q_nxt    = {q_r[VAR_W-3:0], 2'b00};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          done_nxt  = 1'b1;
          phase_nxt = P_IDLE;
        end
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    mr_r  <= mr_nxt;
    mag_r <= mag_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
    big_r <= big_nxt;
  end

  assign res.done = done_r;
  assign res.sd   = mr_r[SD_W-1:0];

endmodule

// ----- rtl/sample_standard_deviation_unit.sv -----
// Throughput: one sample per cycle while a set accumulates.
// After the last sample of a set, in_tready stays low until the result moves
// to the output register. For two samples or more, the result comes from the
// shift-add products, the 97-step divide and the 32-step root, all on one adder.
// Reset: synchronous, active low; clears count, sums, drop flag and output valid.
// ----------------------------------------------------------------------------
// sample_standard_deviation_unit
// Accumulates count, sum and sum of squares of a set of samples and emits the
// sample standard deviation with 8 fraction bits on the last sample.
// ----------------------------------------------------------------------------
`include "sample_standard_deviation_unit_assert.svh"

module sample_standard_deviation_unit
  import ssd_pkg::*;
#(
  parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [DATA_W-1:0]   in_tdata,   // [23:0] sample
  input  logic                in_tlast,   // is_last
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [55:0]         out_tdata,  // [31:0] std_dev, [48:32] sample_count
  output logic [STAT_W-1:0]   out_tuser   // [1:0] status
);

  localparam logic [1:0] ST_ACC   = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SSQ_W-1:0]         ssq_r, ssq_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     pend_vld_r, pend_vld_nxt;
  logic signed [DATA_W-1:0] pend_r, pend_nxt;
  logic                     start_r, start_nxt;
  logic [SD_W-1:0]          res_sd_r, res_sd_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic [SD_W-1:0]          out_sd_r, out_sd_nxt;
  logic [CNT_W-1:0]         out_cnt_r, out_cnt_nxt;
  logic [STAT_W-1:0]        out_stat_r, out_stat_nxt;

  logic                         accept, keep, fin_go;
  logic signed [SAMPLE_WIDTH-1:0] smp_raw;
  logic [DATA_W-1:0]            pmag;
  logic [2*DATA_W-1:0]          psq;
  ssd_opnd_t                    opnd;
  ssd_res_t                     eng_res;

  assign in_tready = (state_r == ST_ACC);
  assign accept    = in_tvalid & in_tready;
  assign keep      = (count_r < CNT_W'(MAX_SAMPLES));
  assign smp_raw   = in_tdata[SAMPLE_WIDTH-1:0];
  assign fin_go    = (state_r == ST_FIN) & (~out_vld_r | out_tready);

  assign pmag = pend_r[DATA_W-1] ? DATA_W'(~pend_r + DATA_W'(1)) : pend_r;
  assign psq  = pmag * pmag;

  assign opnd.n   = count_r;
  assign opnd.sum = sum_r;
  assign opnd.ssq = ssq_r;

  ssd_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .opnd  (opnd),
    .res   (eng_res)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    ssq_nxt      = ssq_r;
    ovf_nxt      = ovf_r;
    pend_vld_nxt = 1'b0;
    pend_nxt     = pend_r;
    start_nxt    = 1'b0;
    res_sd_nxt   = res_sd_r;
    out_vld_nxt  = out_vld_r & ~out_tready;
    out_sd_nxt   = out_sd_r;
    out_cnt_nxt  = out_cnt_r;
    out_stat_nxt = out_stat_r;

    // squares land in the cycle after the transaction
    if (pend_vld_r) begin
      sum_nxt = sum_r + SUM_W'(pend_r);
      ssq_nxt = ssq_r + SSQ_W'(psq);
    end

    unique case (state_r)
      ST_ACC: begin
        if (accept) begin
          if (keep) begin
            count_nxt    = count_r + 1'b1;
            pend_vld_nxt = 1'b1;
            pend_nxt     = DATA_W'(smp_raw);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (count_r >= CNT_W'(2)) begin
          start_nxt = 1'b1;
          state_nxt = ST_CALC;
        end else begin
          res_sd_nxt = '0;
          state_nxt  = ST_FIN;
        end
      end
      ST_CALC: begin
        if (eng_res.done) begin
          res_sd_nxt = eng_res.sd;
          state_nxt  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_vld_nxt = 1'b1;
          out_sd_nxt  = res_sd_r;
          out_cnt_nxt = count_r;
          if (ovf_r) begin
            out_stat_nxt = STAT_DROP;
          end else if (count_r < CNT_W'(2)) begin
            out_stat_nxt = STAT_SINGLE;
          end else begin
            out_stat_nxt = STAT_OK;
          end
          count_nxt = '0;
          sum_nxt   = '0;
          ssq_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_ACC;
      count_r    <= '0;
      sum_r      <= '0;
      ssq_r      <= '0;
      ovf_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      start_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      ssq_r      <= ssq_nxt;
      ovf_r      <= ovf_nxt;
      pend_vld_r <= pend_vld_nxt;
      start_r    <= start_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    res_sd_r   <= res_sd_nxt;
    out_sd_r   <= out_sd_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, out_cnt_r, out_sd_r};
  assign out_tuser  = out_stat_r;

  `SSD_ASSERT_IMPL(a_cnt_max, 1'b1, count_r <= CNT_W'(MAX_SAMPLES))
  `SSD_ASSERT_IMPL(a_ovf_full, ovf_r, count_r == CNT_W'(MAX_SAMPLES))
  `SSD_ASSERT_IMPL(a_done_calc, eng_res.done, state_r == ST_CALC)
  `SSD_ASSERT_NEXT(a_last_drain, accept && in_tlast, state_r == ST_DRAIN)
  `SSD_ASSERT_NEXT(a_fin_clear, fin_go, count_r == '0 && !ovf_r && out_vld_r)

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for sample_standard_deviation_unit
// Drives sets of signed samples over the input stream and predicts, for every
// set, the deviation, the kept sample count and the status. A scoreboard class
// holds its own count and sums and compares each output transaction field by
// field. Stimulus: small directed sets for the extremes, then random sets with
// random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import ssd_pkg::*;

  localparam int MAX_N        = DEF_MAX_SAMPLES;
  localparam int RANDOM_ITEMS = 1950;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT  = 5000;

  localparam logic [DATA_W-1:0] SMP_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SMP_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] SMP_ZERO = '0;
  localparam logic [DATA_W-1:0] SMP_NEG1 = '1;

  typedef enum int {STY_WIDE, STY_NARROW, STY_EXTREME, STY_FLAT} sample_style_t;

  typedef struct packed {
    logic [SD_W-1:0]   dev;
    logic [CNT_W-1:0]  cnt;
    logic [STAT_W-1:0] stat;
  } ssd_result_t;

  class deviation_scoreboard;
    logic [CNT_W-1:0] n_acc;
    logic [SUM_W-1:0] sum_acc;
    logic [SSQ_W-1:0] ssq_acc;
    bit               dropped;
    ssd_result_t      result_q[$];
    int               fails;
    int               checked;

    function new();
      n_acc   = '0;
      sum_acc = '0;
      ssq_acc = '0;
      dropped = 1'b0;
      fails   = 0;
      checked = 0;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    function logic [SD_W-1:0] deviation(logic [CNT_W-1:0] n, logic [SUM_W-1:0] s,
                                        logic [SSQ_W-1:0] ss);
      logic [SUM_W-1:0] smag;
      logic [127:0]     nss;
      logic [127:0]     s2;
      logic [127:0]     num;
      logic [127:0]     den;
      logic [127:0]     q;
      logic [63:0]      scaled_var;
      logic [63:0]      root;
      smag = s[SUM_W-1] ? (~s + 1'b1) : s;
      nss  = 128'(n) * 128'(ss);
      s2   = 128'(smag) * 128'(smag);
      num  = (nss >= s2) ? ((nss - s2) << FRAC_SHIFT) : '0;
      den  = 128'(n) * 128'(n - 1'b1);
      q    = num / den;
      scaled_var = (q[127:64] != '0) ? '1 : q[63:0];
      root = int_sqrt(scaled_var);
      return root[SD_W-1:0];
    endfunction

    // Accumulate one accepted sample; close the set on last.
    function void note_sample(logic [DATA_W-1:0] s, logic last);
      logic [DATA_W-1:0] mag;
      ssd_result_t       r;
      if (int'(n_acc) < MAX_N) begin
        mag     = s[DATA_W-1] ? (~s + 1'b1) : s;
        sum_acc = sum_acc + {{(SUM_W-DATA_W){s[DATA_W-1]}}, s};
        ssq_acc = ssq_acc + SSQ_W'(mag) * SSQ_W'(mag);
        n_acc   = n_acc + 1'b1;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        r.cnt = n_acc;
        r.dev = (n_acc >= 2) ? deviation(n_acc, sum_acc, ssq_acc) : '0;
        if (dropped) r.stat = STAT_DROP;
        else if (n_acc < 2) r.stat = STAT_SINGLE;
        else r.stat = STAT_OK;
        result_q.push_back(r);
        n_acc   = '0;
        sum_acc = '0;
        ssq_acc = '0;
        dropped = 1'b0;
      end
    endfunction

    function void check_result(logic [55:0] data, logic [STAT_W-1:0] user);
      ssd_result_t want;
      logic [SD_W-1:0]  got_dev;
      logic [CNT_W-1:0] got_cnt;
      got_dev = data[SD_W-1:0];
      got_cnt = data[SD_W +: CNT_W];
      checked++;
      if (result_q.size() == 0) begin
        $error("unexpected result: std_dev %0d sample_count %0d status %0d",
               got_dev, got_cnt, user);
        fails++;
        return;
      end
      want = result_q.pop_front();
      if (got_dev !== want.dev) begin
        $error("std_dev: expected %0d, actual %0d", want.dev, got_dev);
        fails++;
      end
      if (got_cnt !== want.cnt) begin
        $error("sample_count: expected %0d, actual %0d", want.cnt, got_cnt);
        fails++;
      end
      if (user !== want.stat) begin
        $error("status: expected %0d, actual %0d", want.stat, user);
        fails++;
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;   // [23:0] sample
  logic              in_tlast   = 1'b0; // is_last
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [55:0]       out_tdata;         // [31:0] std_dev, [48:32] sample_count
  logic [STAT_W-1:0] out_tuser;         // [1:0] status

  deviation_scoreboard sb;
  bit steady       = 1'b0;
  int samples_sent = 0;
  int sets_sent    = 0;
  int stall_cycles = 0;

  sample_standard_deviation_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(input logic [DATA_W-1:0] s, input logic last);
    while (!steady && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(s, last);
    samples_sent++;
    if (last) sets_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted result is out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [DATA_W-1:0] pick_sample(sample_style_t style,
                                                     logic [DATA_W-1:0] base);
    int k;
    case (style)
      STY_WIDE: return DATA_W'($urandom);
      STY_NARROW: begin
        k = $urandom_range(511) - 256;
        return DATA_W'(k);
      end
      STY_EXTREME: begin
        case ($urandom_range(3))
          0: return SMP_MIN;
          1: return SMP_MAX;
          2: return SMP_ZERO;
          default: return SMP_NEG1;
        endcase
      end
      default: begin
        if ($urandom_range(9) == 0) return base ^ (DATA_W'(1) << $urandom_range(DATA_W-1));
        return base;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, sb.pending());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus two long hold-offs once results flow.
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holds_done < 2 && sb.checked >= (holds_done == 0 ? 20 : 50)) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin : sender
    int            set_idx;
    int            len;
    int            r;
    int            start_items;
    sample_style_t style;
    logic [DATA_W-1:0] base;
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-sample sets at the extremes
    send_sample(SMP_MAX, 1'b1);
    send_sample(SMP_MIN, 1'b1);
    send_sample(SMP_ZERO, 1'b1);
    // widest spread, flat sets, small values
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b1);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MIN, 1'b1);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MAX, 1'b1);
    send_sample(SMP_ZERO, 1'b0);
    send_sample(24'd1, 1'b1);
    send_sample(SMP_NEG1, 1'b0);
    send_sample(24'd1, 1'b0);
    send_sample(SMP_NEG1, 1'b0);
    send_sample(24'd1, 1'b1);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_ZERO, 1'b1);
    wait_drained();

    set_idx     = 0;
    start_items = samples_sent;
    while (samples_sent - start_items < RANDOM_ITEMS) begin
      steady = (set_idx >= 30 && set_idx < 60);
      if (set_idx == 20) wait_drained();
      r = $urandom_range(99);
      if (r < 10) len = 1;
      else if (r < 75) len = $urandom_range(16, 2);
      else if (r < 95) len = $urandom_range(64, 17);
      else len = $urandom_range(300, 65);
      style = sample_style_t'($urandom_range(3));
      base  = DATA_W'($urandom);
      for (int i = 0; i < len; i++) send_sample(pick_sample(style, base), i == len - 1);
      set_idx++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d sets over %0d samples: directed extremes and single samples,",
             sets_sent, samples_sent);
    $display("then random sets under stalls on both sides; %0d results checked.",
             sb.checked);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
